// ===== rtl/lcdws_pkg.sv =====
package lcdws_pkg;

  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SETUP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WAIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_WAIT  = 2'd3;

  localparam logic [COUNT_W-1:0] SETUP_RESET      = 16'd1;
  localparam logic [COUNT_W-1:0] ENABLE_RESET     = 16'd1;
  localparam logic [COUNT_W-1:0] SHORT_WAIT_RESET = 16'd74;
  localparam logic [COUNT_W-1:0] LONG_WAIT_RESET  = 16'd3040;

  // clear display and return home instruction codes
  localparam logic [BYTE_W-1:0] INSTR_CLEAR     = 8'h01;
  localparam logic [BYTE_W-1:0] INSTR_HOME      = 8'h02;
  localparam logic [BYTE_W-1:0] INSTR_HOME_MASK = 8'hfe;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SETUP  = 2'd1,
    PH_ENABLE = 2'd2,
    PH_WAIT   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [COUNT_W-1:0] setup_ticks;
    logic [COUNT_W-1:0] enable_ticks;
    logic [COUNT_W-1:0] short_wait_ticks;
    logic [COUNT_W-1:0] long_wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic              command;
    logic              reg_select;
    logic [BYTE_W-1:0] write_byte;
  } in_item_t;

  typedef struct packed {
    logic              enable_pin;
    logic              select_pin;
    logic [BYTE_W-1:0] bus_value;
    logic              bus_drive;
    logic              busy_res;
    logic              refused;
  } out_item_t;

  // clear and home need the long post-write wait, data writes never do
  function automatic logic needs_long_wait(input logic rs, input logic [BYTE_W-1:0] b);
    return (rs == 1'b0) &&
           ((b == INSTR_CLEAR) || ((b & INSTR_HOME_MASK) == INSTR_HOME));
  endfunction

endpackage

// ===== rtl/lcdws_if.sv =====
interface lcdws_in_if;
  logic                             valid;
  logic                             ready;
  logic                             command;
  logic                             reg_select;
  logic [lcdws_pkg::BYTE_W-1:0]     write_byte;

  modport source (output valid, output command, output reg_select, output write_byte,
                  input ready);
  modport sink   (input valid, input command, input reg_select, input write_byte,
                  output ready);
endinterface

interface lcdws_out_if;
  logic                             valid;
  logic                             ready;
  logic                             enable_pin;
  logic                             select_pin;
  logic [lcdws_pkg::BYTE_W-1:0]     bus_value;
  logic                             bus_drive;
  logic                             busy_res;
  logic                             refused;

  modport source (output valid, output enable_pin, output select_pin, output bus_value,
                  output bus_drive, output busy_res, output refused, input ready);
  modport sink   (input valid, input enable_pin, input select_pin, input bus_value,
                  input bus_drive, input busy_res, input refused, output ready);
endinterface

// ===== rtl/lcdws_cfg_regs.sv =====
module lcdws_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               we,
  input  logic [lcdws_pkg::CFG_IDX_W-1:0]    index,
  input  logic [lcdws_pkg::COUNT_W-1:0]      wdata,
  output lcdws_pkg::cfg_t                    cfg
);

  lcdws_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setup_ticks      <= lcdws_pkg::SETUP_RESET;
      cfg_r.enable_ticks     <= lcdws_pkg::ENABLE_RESET;
      cfg_r.short_wait_ticks <= lcdws_pkg::SHORT_WAIT_RESET;
      cfg_r.long_wait_ticks  <= lcdws_pkg::LONG_WAIT_RESET;
    end else if (we) begin
      unique case (index)
        lcdws_pkg::CFG_SETUP:      cfg_r.setup_ticks      <= wdata;
        lcdws_pkg::CFG_ENABLE:     cfg_r.enable_ticks     <= wdata;
        lcdws_pkg::CFG_SHORT_WAIT: cfg_r.short_wait_ticks <= wdata;
        lcdws_pkg::CFG_LONG_WAIT:  cfg_r.long_wait_ticks  <= wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/lcdws_seq.sv =====
module lcdws_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  lcdws_pkg::in_item_t  item,
  output logic                 item_take,
  input  lcdws_pkg::cfg_t      cfg,
  output logic                 res_valid,
  input  logic                 res_ready,
  output lcdws_pkg::out_item_t res
);

  lcdws_pkg::phase_t                 phase_r, phase_nxt;
  logic [lcdws_pkg::COUNT_W-1:0]     ticks_r, ticks_nxt;
  logic [lcdws_pkg::BYTE_W-1:0]      byte_r, byte_nxt;
  logic                              sel_r, sel_nxt;
  logic                              long_r, long_nxt;
  logic                              res_valid_r;
  lcdws_pkg::out_item_t              res_r, res_nxt;
  logic                              refused;
  logic                              driving;

  // result register frees up when empty or taken this cycle
  assign item_take = item_valid && (!res_valid_r || res_ready);

  always_comb begin
    phase_nxt = phase_r;
    ticks_nxt = ticks_r;
    byte_nxt  = byte_r;
    sel_nxt   = sel_r;
    long_nxt  = long_r;
    refused   = 1'b0;
    if (item.command == lcdws_pkg::CMD_WRITE) begin
      if (phase_r != lcdws_pkg::PH_IDLE) begin
        refused = 1'b1;
      end else begin
        byte_nxt  = item.write_byte;
        sel_nxt   = item.reg_select;
        long_nxt  = lcdws_pkg::needs_long_wait(item.reg_select, item.write_byte);
        phase_nxt = lcdws_pkg::PH_SETUP;
        ticks_nxt = cfg.setup_ticks;
      end
    end else if (phase_r != lcdws_pkg::PH_IDLE) begin
      if (ticks_r <= lcdws_pkg::COUNT_W'(1)) begin
        unique case (phase_r)
          lcdws_pkg::PH_SETUP: begin
            phase_nxt = lcdws_pkg::PH_ENABLE;
            ticks_nxt = cfg.enable_ticks;
          end
          lcdws_pkg::PH_ENABLE: begin
            phase_nxt = lcdws_pkg::PH_WAIT;
            ticks_nxt = long_r ? cfg.long_wait_ticks : cfg.short_wait_ticks;
          end
          default: begin
            phase_nxt = lcdws_pkg::PH_IDLE;
            ticks_nxt = '0;
          end
        endcase
      end else begin
        ticks_nxt = ticks_r - lcdws_pkg::COUNT_W'(1);
      end
    end

    driving            = (phase_nxt == lcdws_pkg::PH_SETUP) ||
                         (phase_nxt == lcdws_pkg::PH_ENABLE);
    res_nxt.enable_pin = (phase_nxt == lcdws_pkg::PH_ENABLE);
    res_nxt.select_pin = sel_nxt;
    res_nxt.bus_value  = driving ? byte_nxt : '0;
    res_nxt.bus_drive  = driving;
    res_nxt.busy_res   = (phase_nxt != lcdws_pkg::PH_IDLE);
    res_nxt.refused    = refused;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lcdws_pkg::PH_IDLE;
      ticks_r <= '0;
      byte_r  <= '0;
      sel_r   <= 1'b0;
      long_r  <= 1'b0;
    end else if (item_take) begin
      phase_r <= phase_nxt;
      ticks_r <= ticks_nxt;
      byte_r  <= byte_nxt;
      sel_r   <= sel_nxt;
      long_r  <= long_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (item_take) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  a_write_when_idle_starts_setup: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && item.command == lcdws_pkg::CMD_WRITE && phase_r == lcdws_pkg::PH_IDLE
    |=> phase_r == lcdws_pkg::PH_SETUP && res_r.bus_drive && !res_r.refused)
    else $error("write while idle did not start the setup phase");

  a_refuse_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && phase_r == lcdws_pkg::PH_IDLE |=> !res_r.refused)
    else $error("write refused while idle");

  a_state_holds_without_item: assert property (@(posedge clk) disable iff (!rst_n)
    !item_take |=> $stable(phase_r) && $stable(ticks_r))
    else $error("sequencer state moved without an item");

  a_enable_inside_drive: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.enable_pin |-> res_r.bus_drive && res_r.busy_res)
    else $error("enable raised without the bus driven");

endmodule

// ===== rtl/char_lcd_write_sequencer_core.sv =====
// path: an item passes through the input register and then the result register
// throughput: one item per cycle while the output is not stalled, with a single pass through the phase update logic
// output stalls back up through the result register and the input register without losing items
// reset: synchronous, active low; phase idle, counts and held byte cleared, registers to defaults
// configuration writes take effect on the next phase entered
module char_lcd_write_sequencer_core (
  input  logic                            clk,
  input  logic                            rst_n,
  lcdws_in_if.sink                        in_chan,
  lcdws_out_if.source                     out_chan,
  input  logic                            cfg_we,
  input  logic [lcdws_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lcdws_pkg::COUNT_W-1:0]   cfg_wdata
);

  // input register stage
  logic                 in_valid_r;
  lcdws_pkg::in_item_t  in_item_r;
  logic                 seq_take;

  // configuration counts as one group
  lcdws_pkg::cfg_t      cfg;

  // sequencer result
  lcdws_pkg::out_item_t res;
  logic                 res_valid;

  // the input register refills whenever it is empty or passes its item on this cycle
  assign in_chan.ready = !in_valid_r || seq_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  // payload needs no reset, only the valid flag
  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_item_r.command    <= in_chan.command;
      in_item_r.reg_select <= in_chan.reg_select;
      in_item_r.write_byte <= in_chan.write_byte;
    end
  end

  lcdws_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  // phase state and result register
  lcdws_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid_r),
    .item       (in_item_r),
    .item_take  (seq_take),
    .cfg        (cfg),
    .res_valid  (res_valid),
    .res_ready  (out_chan.ready),
    .res        (res)
  );

  // result channel straight from the result register
  assign out_chan.valid      = res_valid;
  assign out_chan.enable_pin = res.enable_pin;
  assign out_chan.select_pin = res.select_pin;
  assign out_chan.bus_value  = res.bus_value;
  assign out_chan.bus_drive  = res.bus_drive;
  assign out_chan.busy_res   = res.busy_res;
  assign out_chan.refused    = res.refused;

endmodule
